[src/ppmg_pkg.sv]
// Shared widths, result codes and result types for the ASCII PPM to gray stream block.
// Used by the luma unit, the parser, the output queue, the top level, the checker and the testbench.
`default_nettype none

package ppmg_pkg;

    localparam int GRAY_W   = 16;
    localparam int STATUS_W = 3;
    localparam int DIM_O_W  = 13;
    localparam int REPORT_W = 17;
    localparam int COUNT_W  = 25;
    localparam int TOKEN_W  = 17;
    localparam int ACC_W    = 23;

    localparam logic KIND_PIXEL  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam logic [STATUS_W-1:0] STAT_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_HEADER  = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_SAMPLE  = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_EOF_HDR = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_EOF_PIX = 3'd4;

    typedef struct packed {
        logic                kind;
        logic [GRAY_W-1:0]   gray;
        logic [STATUS_W-1:0] status;
        logic [DIM_O_W-1:0]  wide;
        logic [DIM_O_W-1:0]  tall;
        logic [REPORT_W-1:0] report;
        logic [COUNT_W-1:0]  pixels;
        logic                last;
    } t_result;

    // Up to two results leave the parser for one byte; b is valid only with a.
    typedef struct packed {
        logic    va;
        logic    vb;
        t_result a;
        t_result b;
    } t_emit;

endpackage

`default_nettype wire

[src/ppmg_luma.sv]
// Luma of one RGB triple: adds the blue term to the red/green sum and divides by 100.
// Depends on ppmg_pkg for the accumulator and gray widths.
`default_nettype none

module ppmg_luma (
    input  wire logic [ppmg_pkg::ACC_W-1:0]  i_acc,
    input  wire logic [15:0]                 i_blue,
    output logic      [ppmg_pkg::GRAY_W-1:0] o_gray
);
    import ppmg_pkg::*;

    localparam int RECIP_W = 24;
    localparam int SHIFT   = 30;
    // ceil(2^30 / 100); the error term stays small enough for sums below 2^23.
    localparam logic [RECIP_W-1:0] RECIP = 24'd10737419;
    localparam logic [ACC_W-1:0]   COEF_B = 23'd11;
    localparam int PROD_W = ACC_W + RECIP_W;

    logic [ACC_W-1:0]  sum;
    logic [PROD_W-1:0] prod;

    always_comb begin
        sum    = i_acc + ACC_W'(i_blue) * COEF_B;
        prod   = PROD_W'(sum) * PROD_W'(RECIP);
        o_gray = GRAY_W'(prod >> SHIFT);
    end

endmodule

`default_nettype wire

[src/ppmg_parser.sv]
// Token parser and pixel state of the PPM to gray block; one byte per fire.
// Depends on ppmg_pkg and instantiates ppmg_luma for the gray value.
`default_nettype none

module ppmg_parser #(
    parameter int MAX_DIM = 4096
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_fire,
    input  wire logic [7:0]      i_byte,
    input  wire logic            i_eof,
    output ppmg_pkg::t_emit      o_emit
);
    import ppmg_pkg::*;

    localparam int DIM_W  = $clog2(MAX_DIM + 1);
    localparam int AREA_W = 2 * DIM_W;
    localparam int CMP_W  = (AREA_W > COUNT_W) ? AREA_W : COUNT_W;

    typedef enum logic [4:0] {
        ST_MAGIC  = 5'b00001,
        ST_WIDTH  = 5'b00010,
        ST_HEIGHT = 5'b00100,
        ST_MAXVAL = 5'b01000,
        ST_PIXELS = 5'b10000
    } t_stage;

    localparam logic [1:0] MM_EMPTY = 2'd0;
    localparam logic [1:0] MM_P     = 2'd1;
    localparam logic [1:0] MM_P3    = 2'd2;
    localparam logic [1:0] MM_BAD   = 2'd3;

    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_NL    = 8'd10;
    localparam logic [7:0] CH_HASH  = 8'd35;
    localparam logic [7:0] CH_P     = 8'd80;
    localparam logic [7:0] CH_3     = 8'd51;
    localparam logic [7:0] CH_0     = 8'd48;
    localparam logic [7:0] CH_9     = 8'd57;

    localparam logic [TOKEN_W-1:0] TOKEN_SAT = 17'd65536;
    localparam logic [TOKEN_W-1:0] DIM_MAX   = TOKEN_W'(MAX_DIM);
    localparam logic [ACC_W-1:0]   COEF_R    = 23'd30;
    localparam logic [ACC_W-1:0]   COEF_G    = 23'd59;

    t_stage              r_stage, n_stage;
    logic [TOKEN_W-1:0]  r_tok_val, n_tok_val;
    logic                r_tok_present, n_tok_present;
    logic                r_tok_bad, n_tok_bad;
    logic [1:0]          r_magic, n_magic;
    logic                r_comment, n_comment;
    logic [DIM_W-1:0]    r_width, n_width;
    logic [DIM_W-1:0]    r_height, n_height;
    logic [AREA_W-1:0]   r_area, n_area;
    logic [15:0]         r_max, n_max;
    logic [1:0]          r_chan, n_chan;
    logic [ACC_W-1:0]    r_acc, n_acc;
    logic [COUNT_W-1:0]  r_count, n_count;
    logic [GRAY_W-1:0]   r_peak, n_peak;
    logic                r_finished, n_finished;

    logic [GRAY_W-1:0]   gray;
    logic                is_sep;
    logic                do_close;
    logic                pixel_out;
    logic                fin;
    logic [STATUS_W-1:0] fin_status;
    logic [19:0]         tok_next;
    logic                dim_ok;
    logic [ACC_W-1:0]    sample_ext;
    t_result             pix_res;
    t_result             stat_res;

    ppmg_luma u_luma (
        .i_acc  (r_acc),
        .i_blue (r_tok_val[15:0]),
        .o_gray (gray)
    );

    always_comb begin
        n_stage       = r_stage;
        n_tok_val     = r_tok_val;
        n_tok_present = r_tok_present;
        n_tok_bad     = r_tok_bad;
        n_magic       = r_magic;
        n_comment     = r_comment;
        n_width       = r_width;
        n_height      = r_height;
        n_area        = r_area;
        n_max         = r_max;
        n_chan        = r_chan;
        n_acc         = r_acc;
        n_count       = r_count;
        n_peak        = r_peak;
        pixel_out     = 1'b0;
        fin           = 1'b0;
        fin_status    = STAT_OK;

        is_sep   = i_byte inside {CH_SPACE, CH_NL, CH_HASH};
        do_close = i_eof || (!r_comment && is_sep);
        tok_next = {r_tok_val, 3'b000} + {2'b00, r_tok_val, 1'b0}
                   + 20'(i_byte - CH_0);
        dim_ok   = !r_tok_bad && (r_tok_val >= TOKEN_W'(1)) && (r_tok_val <= DIM_MAX);
        sample_ext = ACC_W'(r_tok_val[15:0]);

        if (i_fire && !r_finished) begin
            if (!i_eof) begin
                if (r_comment) begin
                    if (i_byte == CH_NL) begin
                        n_comment = 1'b0;
                    end
                end else if (i_byte == CH_HASH) begin
                    n_comment = 1'b1;
                end else if (!is_sep) begin
                    if (r_magic == MM_EMPTY && i_byte == CH_P) begin
                        n_magic = MM_P;
                    end else if (r_magic == MM_P && i_byte == CH_3) begin
                        n_magic = MM_P3;
                    end else begin
                        n_magic = MM_BAD;
                    end
                    if (i_byte inside {[CH_0:CH_9]}) begin
                        n_tok_val = (tok_next > 20'(TOKEN_SAT)) ? TOKEN_SAT
                                                                : tok_next[TOKEN_W-1:0];
                    end else begin
                        n_tok_bad = 1'b1;
                    end
                    n_tok_present = 1'b1;
                end
            end

            if (do_close) begin
                n_tok_val     = '0;
                n_tok_present = 1'b0;
                n_tok_bad     = 1'b0;
                n_magic       = MM_EMPTY;
                if (r_tok_present) begin
                    case (r_stage)
                        ST_MAGIC: begin
                            if (r_magic == MM_P3) begin
                                n_stage = ST_WIDTH;
                            end else begin
                                fin = 1'b1;
                                fin_status = STAT_HEADER;
                            end
                        end
                        ST_WIDTH: begin
                            if (dim_ok) begin
                                n_width = r_tok_val[DIM_W-1:0];
                                n_stage = ST_HEIGHT;
                            end else begin
                                fin = 1'b1;
                                fin_status = STAT_HEADER;
                            end
                        end
                        ST_HEIGHT: begin
                            if (dim_ok) begin
                                n_height = r_tok_val[DIM_W-1:0];
                                n_area   = AREA_W'(r_width) * AREA_W'(r_tok_val[DIM_W-1:0]);
                                n_stage  = ST_MAXVAL;
                            end else begin
                                fin = 1'b1;
                                fin_status = STAT_HEADER;
                            end
                        end
                        ST_MAXVAL: begin
                            if (!r_tok_bad && r_tok_val >= TOKEN_W'(1) && !r_tok_val[16]) begin
                                n_max   = r_tok_val[15:0];
                                n_stage = ST_PIXELS;
                                n_chan  = 2'd0;
                            end else begin
                                fin = 1'b1;
                                fin_status = STAT_HEADER;
                            end
                        end
                        default: begin
                            if (r_tok_bad || r_tok_val > {1'b0, r_max}) begin
                                fin = 1'b1;
                                fin_status = STAT_SAMPLE;
                            end else if (r_chan == 2'd0) begin
                                n_acc  = sample_ext * COEF_R;
                                n_chan = 2'd1;
                            end else if (r_chan == 2'd1) begin
                                n_acc  = r_acc + sample_ext * COEF_G;
                                n_chan = 2'd2;
                            end else begin
                                n_chan    = 2'd0;
                                pixel_out = 1'b1;
                                n_count   = r_count + COUNT_W'(1);
                                if (gray > r_peak) begin
                                    n_peak = gray;
                                end
                                if (CMP_W'(n_count) == CMP_W'(r_area)) begin
                                    fin = 1'b1;
                                    fin_status = STAT_OK;
                                end
                            end
                        end
                    endcase
                end
            end

            if (i_eof && !fin) begin
                fin = 1'b1;
                fin_status = (n_stage == ST_PIXELS) ? STAT_EOF_PIX : STAT_EOF_HDR;
            end
        end

        n_finished = r_finished || fin;

        pix_res        = '0;
        pix_res.kind   = KIND_PIXEL;
        pix_res.gray   = gray;
        pix_res.wide   = DIM_O_W'(n_width);
        pix_res.tall   = DIM_O_W'(n_height);
        pix_res.pixels = n_count;
        pix_res.last   = !fin;

        stat_res        = '0;
        stat_res.kind   = KIND_STATUS;
        stat_res.status = fin_status;
        stat_res.wide   = DIM_O_W'(n_width);
        stat_res.tall   = DIM_O_W'(n_height);
        stat_res.pixels = n_count;
        stat_res.last   = 1'b1;
        case (fin_status)
            STAT_OK:      stat_res.report = REPORT_W'(n_peak);
            STAT_SAMPLE,
            STAT_EOF_PIX: stat_res.report = REPORT_W'(n_peak) + REPORT_W'(1);
            default:      stat_res.report = '0;
        endcase

        o_emit.va = pixel_out || fin;
        o_emit.vb = pixel_out && fin;
        o_emit.a  = pixel_out ? pix_res : stat_res;
        o_emit.b  = stat_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage       <= ST_MAGIC;
            r_tok_val     <= '0;
            r_tok_present <= 1'b0;
            r_tok_bad     <= 1'b0;
            r_magic       <= MM_EMPTY;
            r_comment     <= 1'b0;
            r_width       <= '0;
            r_height      <= '0;
            r_area        <= '0;
            r_max         <= '0;
            r_chan        <= '0;
            r_acc         <= '0;
            r_count       <= '0;
            r_peak        <= '0;
            r_finished    <= 1'b0;
        end else begin
            r_stage       <= n_stage;
            r_tok_val     <= n_tok_val;
            r_tok_present <= n_tok_present;
            r_tok_bad     <= n_tok_bad;
            r_magic       <= n_magic;
            r_comment     <= n_comment;
            r_width       <= n_width;
            r_height      <= n_height;
            r_area        <= n_area;
            r_max         <= n_max;
            r_chan        <= n_chan;
            r_acc         <= n_acc;
            r_count       <= n_count;
            r_peak        <= n_peak;
            r_finished    <= n_finished;
        end
    end

endmodule

`default_nettype wire

[src/ppmg_out_queue.sv]
// Four-entry result queue: takes up to two results per cycle, hands out one word.
// Depends on ppmg_pkg for the result and emit structs.
`default_nettype none

module ppmg_out_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire ppmg_pkg::t_emit   i_emit,
    output logic                   o_room,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output ppmg_pkg::t_result      o_head
);
    import ppmg_pkg::*;

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = PTR_W + 1;

    t_result           r_slot [DEPTH];
    logic [PTR_W-1:0]  r_wptr, n_wptr;
    logic [PTR_W-1:0]  r_rptr, n_rptr;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              pop;

    always_comb begin
        o_valid = (r_cnt != '0);
        o_head  = r_slot[r_rptr];
        // Room for a full pair of results, so the parser never has to stall mid-byte.
        o_room  = (r_cnt <= CNT_W'(DEPTH - 2));
        pop     = o_valid && i_ready;
        n_wptr  = r_wptr + PTR_W'(i_emit.va) + PTR_W'(i_emit.vb);
        n_rptr  = r_rptr + PTR_W'(pop);
        n_cnt   = r_cnt + CNT_W'(i_emit.va) + CNT_W'(i_emit.vb) - CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_emit.va) begin
            r_slot[r_wptr] <= i_emit.a;
        end
        if (i_emit.vb) begin
            r_slot[r_wptr + PTR_W'(1)] <= i_emit.b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

endmodule

`default_nettype wire

[src/ppm_ascii_to_gray_stream.sv]
// Top level of the ASCII PPM (P3) to gray stream block.
// Depends on ppmg_pkg, ppmg_parser (with ppmg_luma) and ppmg_out_queue.
`default_nettype none

// The block takes one byte of an ASCII PPM file per word and returns gray pixels
// and one final status word. A byte passes an input register and is parsed in the
// next cycle, so a new byte is taken every cycle while the queue has room; results
// are registered in a four-entry queue, and input ready drops only while that
// queue holds more than two results, which happens when the consumer stalls. The
// parse cycle holds the token update and the luma divide (one constant-reciprocal
// multiply). After the final status all bytes are taken and dropped. No clearing
// pass is needed after reset.
module ppm_ascii_to_gray_stream #(
    parameter int MAX_DIM = 4096
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire logic [7:0]                         i_in_byte,
    input  wire logic                               i_end_of_file,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output logic                                    o_item_kind,
    output logic [ppmg_pkg::GRAY_W-1:0]             o_gray_value,
    output logic [ppmg_pkg::STATUS_W-1:0]           o_status_code,
    output logic [ppmg_pkg::DIM_O_W-1:0]            o_image_wide,
    output logic [ppmg_pkg::DIM_O_W-1:0]            o_image_tall,
    output logic [ppmg_pkg::REPORT_W-1:0]           o_gray_max_report,
    output logic [ppmg_pkg::COUNT_W-1:0]            o_pixels_done,
    output logic                                    o_is_last
);
    import ppmg_pkg::*;

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_eof;
    logic        room;
    logic        fire;
    t_emit       emit;
    t_result     head;

    always_comb begin
        fire       = r_in_valid && room;
        o_in_ready = !r_in_valid || fire;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_in_byte;
            r_in_eof  <= i_end_of_file;
        end
    end

    ppmg_parser #(
        .MAX_DIM (MAX_DIM)
    ) u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_byte  (r_in_byte),
        .i_eof   (r_in_eof),
        .o_emit  (emit)
    );

    ppmg_out_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_emit  (emit),
        .o_room  (room),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_head  (head)
    );

    always_comb begin
        o_item_kind       = head.kind;
        o_gray_value      = head.gray;
        o_status_code     = head.status;
        o_image_wide      = head.wide;
        o_image_tall      = head.tall;
        o_gray_max_report = head.report;
        o_pixels_done     = head.pixels;
        o_is_last         = head.last;
    end

endmodule

`default_nettype wire

[sim/ppmg_gray_checker.sv]
// Scoreboard for the ASCII PPM to gray stream block: watches both channels,
// predicts every result word from the accepted bytes and compares them.
// Depends on ppmg_pkg for the result layout, the result codes and the port widths.
module ppmg_gray_checker #(
    parameter int MAX_DIM = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  logic [7:0]                    i_in_byte,
    input  logic                          i_end_of_file,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  logic                          i_item_kind,
    input  logic [ppmg_pkg::GRAY_W-1:0]   i_gray_value,
    input  logic [ppmg_pkg::STATUS_W-1:0] i_status_code,
    input  logic [ppmg_pkg::DIM_O_W-1:0]  i_image_wide,
    input  logic [ppmg_pkg::DIM_O_W-1:0]  i_image_tall,
    input  logic [ppmg_pkg::REPORT_W-1:0] i_gray_max_report,
    input  logic [ppmg_pkg::COUNT_W-1:0]  i_pixels_done,
    input  logic                          i_is_last,
    output int                            o_fail_count,
    output int                            o_waiting,
    output int                            o_gray_words,
    output int                            o_status_words
);
    timeunit 1ns;
    timeprecision 1ps;

    import ppmg_pkg::*;

    typedef enum logic [2:0] {PS_MAGIC, PS_WIDTH, PS_HEIGHT, PS_MAXVAL, PS_PIXELS} t_stage;
    typedef enum logic [1:0] {MG_EMPTY, MG_P, MG_P3, MG_BAD} t_magic;

    localparam logic [7:0] CH_NL    = 8'd10;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_HASH  = 8'd35;
    localparam logic [7:0] CH_0     = 8'd48;
    localparam logic [7:0] CH_3     = 8'd51;
    localparam logic [7:0] CH_9     = 8'd57;
    localparam logic [7:0] CH_P     = 8'd80;

    localparam int unsigned TOKEN_SAT  = 65536;
    localparam int unsigned SAMPLE_TOP = 65535;

    // Parser image of the block.
    t_stage               stage;
    int unsigned          tok_val;
    bit                   tok_seen;
    bit                   tok_text;
    t_magic               magic;
    bit                   in_note;
    int unsigned          wide;
    int unsigned          tall;
    int unsigned          maxv;
    int unsigned          chan;
    int unsigned          red_v;
    int unsigned          green_v;
    logic [COUNT_W-1:0]   pix_cnt;
    int unsigned          peak;
    bit                   done;

    t_result gray_due[$];

    int fails     = 0;
    int waiting   = 0;
    int gray_seen = 0;
    int stat_seen = 0;

    assign o_fail_count   = fails;
    assign o_waiting      = waiting;
    assign o_gray_words   = gray_seen;
    assign o_status_words = stat_seen;

    task automatic clear_model();
        stage    = PS_MAGIC;
        tok_val  = 0;
        tok_seen = 0;
        tok_text = 0;
        magic    = MG_EMPTY;
        in_note  = 0;
        wide     = 0;
        tall     = 0;
        maxv     = 0;
        chan     = 0;
        red_v    = 0;
        green_v  = 0;
        pix_cnt  = '0;
        peak     = 0;
        done     = 0;
        gray_due.delete();
    endtask

    task automatic post_word(input logic kind, input int unsigned gray,
                             input logic [2:0] code, input int unsigned rep);
        t_result r;
        r.kind   = kind;
        r.gray   = gray[GRAY_W-1:0];
        r.status = code;
        r.wide   = wide[DIM_O_W-1:0];
        r.tall   = tall[DIM_O_W-1:0];
        r.report = rep[REPORT_W-1:0];
        r.pixels = pix_cnt;
        r.last   = 1'b0;
        gray_due = {gray_due, r};
    endtask

    task automatic close_file(input logic [2:0] code);
        int unsigned rep;
        rep = 0;
        if (code == STAT_OK) begin
            rep = peak;
        end else if (code == STAT_SAMPLE || code == STAT_EOF_PIX) begin
            rep = peak + 1;
        end
        post_word(KIND_STATUS, 0, code, rep);
        done = 1;
    endtask

    task automatic end_token();
        int unsigned v;
        bit          bad;
        bit          seen;
        t_magic      mm;
        int unsigned gray;
        v        = tok_val;
        bad      = tok_text;
        seen     = tok_seen;
        mm       = magic;
        tok_val  = 0;
        tok_seen = 0;
        tok_text = 0;
        magic    = MG_EMPTY;
        if (!seen || done) return;
        case (stage)
            PS_MAGIC: begin
                if (mm == MG_P3) stage = PS_WIDTH;
                else close_file(STAT_HEADER);
            end
            PS_WIDTH: begin
                if (!bad && v >= 1 && v <= MAX_DIM) begin
                    wide  = v;
                    stage = PS_HEIGHT;
                end else begin
                    close_file(STAT_HEADER);
                end
            end
            PS_HEIGHT: begin
                if (!bad && v >= 1 && v <= MAX_DIM) begin
                    tall  = v;
                    stage = PS_MAXVAL;
                end else begin
                    close_file(STAT_HEADER);
                end
            end
            PS_MAXVAL: begin
                if (!bad && v >= 1 && v <= SAMPLE_TOP) begin
                    maxv  = v;
                    stage = PS_PIXELS;
                    chan  = 0;
                end else begin
                    close_file(STAT_HEADER);
                end
            end
            default: begin
                if (bad || v > maxv) begin
                    close_file(STAT_SAMPLE);
                end else if (chan == 0) begin
                    red_v = v;
                    chan  = 1;
                end else if (chan == 1) begin
                    green_v = v;
                    chan    = 2;
                end else begin
                    gray    = (30 * red_v + 59 * green_v + 11 * v) / 100;
                    chan    = 0;
                    pix_cnt = pix_cnt + 1'b1;
                    if (gray > peak) peak = gray;
                    post_word(KIND_PIXEL, gray, STAT_OK, 0);
                    if (longint'(pix_cnt) == longint'(wide) * longint'(tall)) begin
                        close_file(STAT_OK);
                    end
                end
            end
        endcase
    endtask

    task automatic parse_step(input logic [7:0] b, input logic eof);
        int          n0;
        int unsigned nv;
        n0 = gray_due.size();
        if (done) return;
        if (eof) begin
            end_token();
            if (!done) close_file(stage == PS_PIXELS ? STAT_EOF_PIX : STAT_EOF_HDR);
        end else if (in_note) begin
            if (b == CH_NL) in_note = 0;
        end else if (b inside {CH_SPACE, CH_NL}) begin
            end_token();
        end else if (b == CH_HASH) begin
            end_token();
            in_note = 1;
        end else begin
            if (magic == MG_EMPTY && b == CH_P) magic = MG_P;
            else if (magic == MG_P && b == CH_3) magic = MG_P3;
            else magic = MG_BAD;
            if (b inside {[CH_0:CH_9]}) begin
                nv      = tok_val * 10 + int'(b) - int'(CH_0);
                tok_val = (nv > TOKEN_SAT) ? TOKEN_SAT : nv;
            end else begin
                tok_text = 1;
            end
            tok_seen = 1;
        end
        // The last word caused by this byte carries the last flag.
        if (gray_due.size() > n0) begin
            gray_due[gray_due.size() - 1].last = 1'b1;
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (act_v !== exp_v) begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
            fails++;
        end
    endtask

    task automatic check_word();
        t_result e;
        if (gray_due.size() == 0) begin
            $display("%0t ns: unexpected word, expected none, got kind %0d gray %0d status %0d",
                     $time, i_item_kind, i_gray_value, i_status_code);
            fails++;
            return;
        end
        e = gray_due.pop_front();
        check_field("item_kind", e.kind, i_item_kind);
        check_field("gray_value", e.gray, i_gray_value);
        check_field("status_code", e.status, i_status_code);
        check_field("image_wide", e.wide, i_image_wide);
        check_field("image_tall", e.tall, i_image_tall);
        check_field("gray_max_report", e.report, i_gray_max_report);
        check_field("pixels_done", e.pixels, i_pixels_done);
        check_field("is_last", e.last, i_is_last);
        if (e.kind == KIND_PIXEL) gray_seen++;
        else stat_seen++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_model();
        end else begin
            if (i_out_valid && i_out_ready) check_word();
            if (i_in_valid && i_in_ready) parse_step(i_in_byte, i_end_of_file);
        end
        waiting = gray_due.size();
    end

endmodule

[sim/ppm_ascii_to_gray_stream_test.sv]
// Testbench top for the ASCII PPM to gray stream block: builds one PPM file,
// streams it byte by byte under varying backpressure and reports the verdict.
// Depends on ppmg_pkg, ppm_ascii_to_gray_stream and ppmg_gray_checker.
module ppm_ascii_to_gray_stream_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ppmg_pkg::*;

    localparam int MAX_DIM = 4096;
    localparam int FILE_BUDGET = 1500;

    localparam logic [7:0] CH_NL    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_HASH  = 8'd35;

    typedef enum {END_COMPLETE, END_BAD_SAMPLE, END_EOF_PIXELS, END_HEADER} t_ending;
    typedef enum {HF_NONE, HF_MAGIC, HF_MAGIC_LONG, HF_WIDTH_ZERO, HF_WIDTH_BIG,
                  HF_HEIGHT_TEXT, HF_MAXVAL_ZERO, HF_MAXVAL_BIG, HF_EOF} t_header_fault;
    typedef enum {PH_SEND_LIGHT, PH_SEND_HEAVY, PH_FREE} t_phase;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_in_valid    = 1'b0;
    logic [7:0]           i_in_byte     = 8'd0;
    logic                 i_end_of_file = 1'b0;
    logic                 i_out_ready   = 1'b0;
    logic                 o_in_ready;
    logic                 o_out_valid;
    logic                 o_item_kind;
    logic [GRAY_W-1:0]    o_gray_value;
    logic [STATUS_W-1:0]  o_status_code;
    logic [DIM_O_W-1:0]   o_image_wide;
    logic [DIM_O_W-1:0]   o_image_tall;
    logic [REPORT_W-1:0]  o_gray_max_report;
    logic [COUNT_W-1:0]   o_pixels_done;
    logic                 o_is_last;

    int fail_count;
    int waiting;
    int gray_words;
    int status_words;

    logic [8:0] file_words[$];  // {end_of_file, byte}
    t_phase     phase = PH_SEND_LIGHT;
    t_ending    ending;
    int         wide_px;
    int         tall_px;
    int         maxv;

    ppm_ascii_to_gray_stream #(.MAX_DIM(MAX_DIM)) u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_in_byte         (i_in_byte),
        .i_end_of_file     (i_end_of_file),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_item_kind       (o_item_kind),
        .o_gray_value      (o_gray_value),
        .o_status_code     (o_status_code),
        .o_image_wide      (o_image_wide),
        .o_image_tall      (o_image_tall),
        .o_gray_max_report (o_gray_max_report),
        .o_pixels_done     (o_pixels_done),
        .o_is_last         (o_is_last)
    );

    ppmg_gray_checker #(.MAX_DIM(MAX_DIM)) u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .i_in_ready        (o_in_ready),
        .i_in_byte         (i_in_byte),
        .i_end_of_file     (i_end_of_file),
        .i_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .i_item_kind       (o_item_kind),
        .i_gray_value      (o_gray_value),
        .i_status_code     (o_status_code),
        .i_image_wide      (o_image_wide),
        .i_image_tall      (o_image_tall),
        .i_gray_max_report (o_gray_max_report),
        .i_pixels_done     (o_pixels_done),
        .i_is_last         (o_is_last),
        .o_fail_count      (fail_count),
        .o_waiting         (waiting),
        .o_gray_words      (gray_words),
        .o_status_words    (status_words)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int send_idle_pct(input t_phase ph);
        return (ph == PH_SEND_LIGHT) ? 34 : (ph == PH_SEND_HEAVY) ? 62 : 0;
    endfunction

    function automatic int recv_idle_pct(input t_phase ph);
        return (ph == PH_SEND_LIGHT) ? 62 : (ph == PH_SEND_HEAVY) ? 34 : 0;
    endfunction

    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= recv_idle_pct(phase));
    end

    function automatic int digit_count(input int v);
        int d;
        d = 1;
        while (v >= 10) begin
            v = v / 10;
            d++;
        end
        return d;
    endfunction

    task automatic queue_word(input logic [8:0] w);
        file_words = {file_words, w};
    endtask

    task automatic put_byte(input logic [7:0] b);
        queue_word({1'b0, b});
    endtask

    task automatic put_eof();
        queue_word({1'b1, 8'($urandom_range(0, 255))});
    endtask

    task automatic put_text(input string s);
        for (int k = 0; k < s.len(); k++) put_byte(s[k]);
    endtask

    task automatic put_num(input int v);
        if ($urandom_range(0, 11) == 0) begin
            repeat ($urandom_range(1, 3)) put_byte("0");
        end
        put_text($sformatf("%0d", v));
    endtask

    // A comment runs to the newline; its body takes any byte value but the newline.
    task automatic put_note();
        logic [7:0] b;
        put_byte(CH_HASH);
        repeat ($urandom_range(0, 6)) begin
            b = 8'($urandom_range(0, 255));
            if (b == CH_NL) b = 8'h0B;
            put_byte(b);
        end
        put_byte(CH_NL);
    endtask

    task automatic put_sep();
        case ($urandom_range(0, 15))
            9, 10, 11: put_byte(CH_NL);
            12: begin
                repeat ($urandom_range(2, 4)) put_byte($urandom_range(0, 1) ? CH_SPACE : CH_NL);
            end
            13: put_note();
            14: begin
                put_byte(CH_SPACE);
                put_note();
            end
            default: put_byte(CH_SPACE);
        endcase
    endtask

    // Bytes after the end fill the stream up to the byte budget; the block drops them.
    task automatic put_trailer();
        int pad;
        pad = FILE_BUDGET - file_words.size();
        if (pad < 10) pad = 10;
        repeat (pad) put_byte(8'($urandom_range(0, 255)));
        put_eof();
        repeat ($urandom_range(1, 5)) put_byte(8'($urandom_range(0, 255)));
    endtask

    function automatic int pick_sample(input int top, input int p);
        if (p == 0) return top;
        if (p == 1) return 0;
        case ($urandom_range(0, 9))
            0: return 0;
            1: return top;
            2: return $urandom_range(0, (top > 9) ? 9 : top);
            default: return $urandom_range(0, top);
        endcase
    endfunction

    task automatic put_bad_sample(input int top);
        case ($urandom_range(0, 5))
            0: put_text("x");
            1: put_byte(8'($urandom_range(128, 255)));
            2: put_text("12\t3");
            3: put_text("65536");
            4: put_text("9999999");
            default: begin
                if (top < 65535) begin
                    put_num(top + 1);
                end else begin
                    put_text("7");
                    put_byte(CH_CR);
                end
            end
        endcase
        put_sep();
    endtask

    function automatic int pick_big_dim();
        return ($urandom_range(0, 3) == 0) ? MAX_DIM : $urandom_range(16, MAX_DIM);
    endfunction

    task automatic build_file();
        t_header_fault hf;
        int            r;
        int            target;
        int            stop_at;
        int            npix;
        int            ch;
        r = $urandom_range(0, 9);
        ending = (r < 5) ? END_COMPLETE : (r < 7) ? END_BAD_SAMPLE :
                 (r < 9) ? END_EOF_PIXELS : END_HEADER;
        r = $urandom_range(0, 9);
        maxv = (r < 5) ? 65535 : (r == 5) ? 1 : $urandom_range(2, 65534);
        target = FILE_BUDGET / (3 * (digit_count(maxv) + 2));
        stop_at = $urandom_range(target / 2, target);
        if (ending == END_COMPLETE) begin
            wide_px = $urandom_range(1, (target < 40) ? target : 40);
            tall_px = (target / wide_px < 1) ? 1 : target / wide_px;
        end else begin
            wide_px = pick_big_dim();
            tall_px = pick_big_dim();
        end
        hf = HF_NONE;
        if (ending == END_HEADER) hf = t_header_fault'($urandom_range(1, 8));

        // Header, with a comment whose body holds the byte extremes.
        if (hf == HF_MAGIC) put_text("P6");
        else if (hf == HF_MAGIC_LONG) put_text("P33");
        else put_text("P3");
        put_byte(CH_NL);
        put_byte(CH_HASH);
        put_byte(8'h00);
        put_byte(8'hFF);
        put_byte(8'h80);
        put_byte(8'h7F);
        put_byte(CH_NL);
        if (hf != HF_MAGIC && hf != HF_MAGIC_LONG) begin
            put_num((hf == HF_WIDTH_ZERO) ? 0 : (hf == HF_WIDTH_BIG) ? MAX_DIM + 1 : wide_px);
            put_sep();
            if (hf == HF_EOF) begin
                put_eof();
            end else if (hf != HF_WIDTH_ZERO && hf != HF_WIDTH_BIG) begin
                if (hf == HF_HEIGHT_TEXT) put_text("12a");
                else put_num(tall_px);
                put_sep();
                if (hf != HF_HEIGHT_TEXT) begin
                    put_num((hf == HF_MAXVAL_ZERO) ? 0 : (hf == HF_MAXVAL_BIG) ? 65536 : maxv);
                    put_sep();
                end
            end
        end

        if (ending != END_HEADER) begin
            npix = (ending == END_COMPLETE) ? wide_px * tall_px : stop_at;
            for (int p = 0; p < npix; p++) begin
                for (int c = 0; c < 3; c++) begin
                    put_num(pick_sample(maxv, p));
                    put_sep();
                end
            end
            ch = $urandom_range(0, 2);
            if (ending == END_BAD_SAMPLE) begin
                for (int c = 0; c < ch; c++) begin
                    put_num(pick_sample(maxv, 2));
                    put_sep();
                end
                put_bad_sample(maxv);
            end else if (ending == END_EOF_PIXELS) begin
                // The end of file may arrive with a sample token still open.
                for (int c = 0; c < ch; c++) begin
                    put_num(pick_sample(maxv, 2));
                    if (c != ch - 1 || $urandom_range(0, 1)) put_sep();
                end
                put_eof();
            end
        end
        put_trailer();
    endtask

    task automatic send_word(input logic [8:0] w);
        while ($urandom_range(0, 99) < send_idle_pct(phase)) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_in_byte     <= w[7:0];
        i_end_of_file <= w[8];
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    initial begin
        int total;
        build_file();
        total = file_words.size();
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        for (int idx = 0; idx < total; idx++) begin
            phase <= (idx < total / 3) ? PH_SEND_LIGHT :
                     (idx < 2 * total / 3) ? PH_SEND_HEAVY : PH_FREE;
            // Halfway through, hold the sender until the output side has drained.
            if (idx == total / 2) begin
                i_in_valid <= 1'b0;
                @(negedge i_clk);
                while (waiting != 0) @(negedge i_clk);
            end
            send_word(file_words[idx]);
        end
        i_in_valid <= 1'b0;
        while (waiting != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        $display("Streamed %0d file bytes: %0d x %0d header, maxval %0d, %s ending.",
                 total, wide_px, tall_px, maxv, ending.name());
        $display("Compared %0d gray words and %0d status words.", gray_words, status_words);
        if (fail_count == 0) begin
            $display("ppm_ascii_to_gray_stream verification clean");
        end else begin
            $display("ppm_ascii_to_gray_stream verification failed");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Run timed out with %0d words still due.", waiting);
        $display("ppm_ascii_to_gray_stream verification failed");
        $finish;
    end

endmodule

[filelist.f]
src/ppmg_pkg.sv
src/ppmg_luma.sv
src/ppmg_parser.sv
src/ppmg_out_queue.sv
src/ppm_ascii_to_gray_stream.sv
sim/ppmg_gray_checker.sv
sim/ppm_ascii_to_gray_stream_test.sv
